// ----- rtl/kea_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kea_pkg
// Types, constants and the key code table shared by the keypad event tracker.
// ----------------------------------------------------------------------------
package kea_pkg;

  localparam int CODE_COUNT = 18;
  localparam int IDX_W      = 5;
  localparam int TICK_W     = 32;
  localparam int TYPE_W     = 16;
  localparam int CODE_W     = 16;
  localparam int VALUE_W    = 32;
  localparam int CFG_W      = 16;
  localparam int MASK_W     = 18;
  localparam int IN_DATA_W  = TICK_W + TYPE_W + CODE_W + VALUE_W;
  localparam int OUT_DATA_W = 4 * MASK_W;

  localparam logic [TYPE_W-1:0]  EV_KEY         = 16'd1;
  localparam logic [VALUE_W-1:0] VAL_RELEASE    = 32'd0;
  localparam logic [VALUE_W-1:0] VAL_AUTOREPEAT = 32'd2;

  localparam logic FUNC_POLL  = 1'b0;

  localparam logic CFG_DELAY    = 1'b0;
  localparam logic CFG_INTERVAL = 1'b1;

  localparam logic [CFG_W-1:0] DELAY_RST    = 16'd300;
  localparam logic [CFG_W-1:0] INTERVAL_RST = 16'd100;

  typedef logic [CODE_W-1:0] code_tbl_t [CODE_COUNT];

  localparam code_tbl_t CODE_TABLE = '{
    16'd103, 16'd108, 16'd105, 16'd106, 16'd305, 16'd304, 16'd307, 16'd308, 16'd310,
    16'd311, 16'd312, 16'd313, 16'd314, 16'd315, 16'd316, 16'd116, 16'd115, 16'd114
  };

  typedef struct packed {
    logic              poll;
    logic [TICK_W-1:0] tick;
    logic              known;
    logic              press;
    logic [IDX_W-1:0]  idx;
  } kea_cmd_t;

  typedef struct packed {
    logic [1:0] fill;
  } kea_front_stat_t;

  typedef struct packed {
    logic busy;
  } kea_back_stat_t;

  typedef enum logic {
    BK_IDLE,
    BK_SWEEP
  } kea_back_state_t;

  // {hit, index}
  function automatic logic [IDX_W:0] code_lookup(input logic [CODE_W-1:0] code);
    logic [IDX_W:0] res;
    res = '0;
    for (int i = CODE_COUNT - 1; i >= 0; i--) begin
      if (CODE_TABLE[i] == code) begin
        res = {1'b1, IDX_W'(i)};
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/kea_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kea_front
// Accepts requests, decodes poll/key events into commands, two-entry queue.
// ----------------------------------------------------------------------------
module kea_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic                             in_tuser,
  input  wire logic [kea_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  cmd_valid,
  input  wire logic                             cmd_ready,
  output kea_pkg::kea_cmd_t                     cmd,
  output kea_pkg::kea_front_stat_t              stat
);
  import kea_pkg::*;

  logic [TICK_W-1:0]  tick;
  logic [TYPE_W-1:0]  ev_type;
  logic [CODE_W-1:0]  key_code;
  logic [VALUE_W-1:0] key_value;
  logic [IDX_W:0]     hit;
  kea_cmd_t           dec;

  kea_cmd_t   q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push, pop;

  assign tick      = in_tdata[TICK_W-1:0];
  assign ev_type   = in_tdata[TICK_W+TYPE_W-1:TICK_W];
  assign key_code  = in_tdata[TICK_W+TYPE_W+CODE_W-1:TICK_W+TYPE_W];
  assign key_value = in_tdata[IN_DATA_W-1:TICK_W+TYPE_W+CODE_W];
  assign hit       = code_lookup(key_code);

  always_comb begin
    dec.poll  = (in_tuser == FUNC_POLL);
    dec.tick  = tick;
    dec.known = (in_tuser != FUNC_POLL) && (ev_type == EV_KEY) &&
                (key_value != VAL_AUTOREPEAT) && hit[IDX_W];
    dec.press = (key_value != VAL_RELEASE);
    dec.idx   = hit[IDX_W-1:0];
  end

  assign in_tready = (fill_r != 2'd2);
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign stat.fill = fill_r;
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    case ({push, pop})
      2'b10:   fill_nxt = fill_r + 2'd1;
      2'b01:   fill_nxt = fill_r - 2'd1;
      default: fill_nxt = fill_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/kea_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kea_back
// Executes commands: key press/release, poll sweep over repeat times, result reg.
// ----------------------------------------------------------------------------
module kea_back #(
  parameter int NUM_BUTTONS = 18
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_ready,
  input  wire kea_pkg::kea_cmd_t                cmd,
  input  wire logic                             cfg_we,
  input  wire logic                             cfg_index,
  input  wire logic [kea_pkg::CFG_W-1:0]        cfg_data,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [kea_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tuser,
  output kea_pkg::kea_back_stat_t               stat
);
  import kea_pkg::*;

  localparam int IW = $clog2(NUM_BUTTONS);
  localparam int CW = $clog2(NUM_BUTTONS + 1);

  kea_back_state_t state_r, state_nxt;

  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [NUM_BUTTONS-1:0] held_r, held_nxt;
  logic [NUM_BUTTONS-1:0] pe_r, pe_nxt;
  logic [NUM_BUTTONS-1:0] re_r, re_nxt;
  logic [NUM_BUTTONS-1:0] rp_r, rp_nxt;
  logic [TICK_W-1:0]      poll_time_r, poll_time_nxt;
  logic [CFG_W-1:0]       delay_r, delay_nxt;
  logic [CFG_W-1:0]       interval_r, interval_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   out_known_r, out_known_nxt;

  logic [TICK_W-1:0] due_mem [NUM_BUTTONS];
  logic [TICK_W-1:0] rd_q;
  logic [IW-1:0]     rd_addr;
  logic              mem_we;
  logic [IW-1:0]     mem_wa;
  logic [TICK_W-1:0] mem_wd;

  logic                   slot_free;
  logic                   pop;
  logic                   sweep_done;
  logic [IW-1:0]          ev_idx;
  logic [IW-1:0]          proc_idx;
  logic [NUM_BUTTONS-1:0] ev_bit;

  assign slot_free  = !out_valid_r || out_tready;
  assign pop        = cmd_valid && cmd_ready;
  assign sweep_done = (cnt_r == CW'(NUM_BUTTONS));
  assign ev_idx     = IW'(cmd.idx);
  assign proc_idx   = IW'(cnt_r - CW'(1));
  assign rd_addr    = (cnt_r < CW'(NUM_BUTTONS)) ? cnt_r[IW-1:0] : '0;

  always_comb begin
    ev_bit         = '0;
    ev_bit[ev_idx] = 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (pop && cmd.poll) begin
          state_nxt = BK_SWEEP;
        end
      end
      BK_SWEEP: begin
        if (sweep_done) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    cmd_ready     = 1'b0;
    cnt_nxt       = cnt_r;
    held_nxt      = held_r;
    pe_nxt        = pe_r;
    re_nxt        = re_r;
    rp_nxt        = rp_r;
    poll_time_nxt = poll_time_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_known_nxt = out_known_r;
    mem_we        = 1'b0;
    mem_wa        = ev_idx;
    mem_wd        = poll_time_r + TICK_W'(delay_r);
    case (state_r)
      BK_IDLE: begin
        cmd_ready = slot_free;
        if (pop) begin
          if (cmd.poll) begin
            poll_time_nxt = cmd.tick;
            pe_nxt        = '0;
            re_nxt        = '0;
            rp_nxt        = '0;
            cnt_nxt       = '0;
          end else begin
            if (cmd.known) begin
              if (cmd.press) begin
                held_nxt = held_r | ev_bit;
                pe_nxt   = pe_r | ev_bit;
                mem_we   = 1'b1;
              end else begin
                held_nxt = held_r & ~ev_bit;
                re_nxt   = re_r | ev_bit;
              end
            end
            out_valid_nxt = 1'b1;
            out_known_nxt = cmd.known;
          end
        end
      end
      BK_SWEEP: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r != '0) begin
          if (held_r[proc_idx] && (poll_time_r >= rd_q)) begin
            rp_nxt[proc_idx] = 1'b1;
            mem_we           = 1'b1;
            mem_wa           = proc_idx;
            mem_wd           = rd_q + TICK_W'(interval_r);
          end
        end
        if (sweep_done) begin
          out_valid_nxt = 1'b1;
          out_known_nxt = 1'b0;
        end
      end
      default: cmd_ready = 1'b0;
    endcase
    out_data_nxt = {rp_nxt[MASK_W-1:0], re_nxt[MASK_W-1:0],
                    pe_nxt[MASK_W-1:0], held_nxt[MASK_W-1:0]};
  end

  always_comb begin
    delay_nxt    = delay_r;
    interval_nxt = interval_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY:    delay_nxt    = cfg_data;
        CFG_INTERVAL: interval_nxt = cfg_data;
        default:      delay_nxt    = delay_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      due_mem[mem_wa] <= mem_wd;
    end
    rd_q <= due_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (out_valid_nxt && !(out_valid_r && !out_tready)) begin
      out_data_r  <= out_data_nxt;
      out_known_r <= out_known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cnt_r       <= '0;
      held_r      <= '0;
      pe_r        <= '0;
      re_r        <= '0;
      rp_r        <= '0;
      poll_time_r <= '0;
      delay_r     <= DELAY_RST;
      interval_r  <= INTERVAL_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      held_r      <= held_nxt;
      pe_r        <= pe_nxt;
      re_r        <= re_nxt;
      rp_r        <= rp_nxt;
      poll_time_r <= poll_time_nxt;
      delay_r     <= delay_nxt;
      interval_r  <= interval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_known_r;
  assign stat.busy  = (state_r == BK_SWEEP);

endmodule
`default_nettype wire

// ----- rtl/keypad_event_autorepeat.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_event_autorepeat
// Keypad event tracker: press/release edges and software autorepeat per poll.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// in_      in   tvalid/tready      tuser: func; tdata: tick, type, code, value
// out_     out  tvalid/tready      tuser: key_known; tdata: four 18-bit masks
// cfg_     in   valid/ready        index 0 delay, 1 interval; data 16 bits
//
// A key event is executed when its command is taken from the queue; a poll
// sweeps the repeat-time memory through its one read port, and the executor
// takes no command during the sweep. A request is registered in the command
// queue, then in the result register. The front queue holds two requests while
// the executor or result register stalls. Sync reset; no memory clearing pass.
// ----------------------------------------------------------------------------
module keypad_event_autorepeat #(
  parameter int NUM_BUTTONS = 18
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic                           in_tuser,   // func
  // tick[31:0], event_type[47:32], key_code[63:48], key_value[95:64]
  input  wire logic [kea_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic                                out_tuser,  // key_known
  // pressed[17:0], press_edges[35:18], release_edges[53:36], repeat_edges[71:54]
  output logic [kea_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic                           cfg_index,
  input  wire logic [kea_pkg::CFG_W-1:0]      cfg_data
);
  import kea_pkg::*;

  kea_cmd_t        cmd;
  logic            cmd_valid;
  logic            cmd_ready;
  kea_front_stat_t fr_stat;
  kea_back_stat_t  bk_stat;

  assign cfg_ready = 1'b1;

  kea_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .stat      (fr_stat)
  );

  kea_back #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .stat       (bk_stat)
  );

  a_known_has_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      ((out_tdata[2*MASK_W-1:MASK_W] | out_tdata[3*MASK_W-1:2*MASK_W]) != '0))
    else $error("known key result without a press or release edge");

  a_no_pop_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    bk_stat.busy |-> !(cmd_valid && cmd_ready))
    else $error("command taken during poll sweep");

  a_sweep_starts_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(bk_stat.busy) |-> !out_tvalid)
    else $error("poll started while a result was still pending");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (fr_stat.fill == 2'd2) |=> (fr_stat.fill == 2'd2) || (fr_stat.fill == 2'd1))
    else $error("command queue fill jumped");

endmodule
`default_nettype wire
